// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for the concurrent assertions of the line rasterizer.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on the rising clock edge, switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/lr_pkg.sv -----
// ---------------------------------------------------------------------------
// lr_pkg
// Types and constants shared by the line rasterizer modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lr_pkg;

	localparam int COORD_BITS_DEF = 10;
	localparam int QUEUE_DEPTH    = 4;
	localparam int COLOR_BITS     = 32;

	typedef enum logic [0:0] {
		REQ_LOAD = 1'b0,
		REQ_STEP = 1'b1
	} req_type_t;

	typedef struct packed {
		logic is_load;
		logic steep;
		logic minor_dec;
	} cmd_flags_t;

endpackage

`default_nettype wire

// ----- hw/rtl/line_rasterizer.sv -----
// ---------------------------------------------------------------------------
// line_rasterizer
// Bresenham line rasterizer: a load word sets up a line, each step word
// returns the next pixel of it while the line lasts.
// ---------------------------------------------------------------------------
//  Channel  | Direction | Fields (lowest bit first)
//  s_axis   | in        | tuser: req_type; tdata: x_start, y_start, x_end, y_end, color
//  m_axis   | out       | tdata: pixel_x, pixel_y, pixel_color; tlast: last_pixel
//
// One input word is taken per clock while the queue is not full; a step word is
// written to the queue when accepted, then the stepper and the output register
// take it and its pixel shows on m_axis.
// The stepper updates the coordinates and error term and checks for the last pixel.
// Reset empties the queue, clears the output valid flag and leaves no line active.
// A stall on m_axis holds the stepper; the four-entry queue takes words until full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module line_rasterizer #(
	parameter int  COORD_BITS = lr_pkg::COORD_BITS_DEF,
	localparam int IN_W  = ((4 * COORD_BITS + lr_pkg::COLOR_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((2 * COORD_BITS + lr_pkg::COLOR_BITS + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire logic [IN_W-1:0]  s_axis_tdata,  // x_start, y_start, x_end, y_end, color
	input  wire logic             s_axis_tuser,  // req_type
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	output logic [OUT_W-1:0]      m_axis_tdata,  // pixel_x, pixel_y, pixel_color
	output logic                  m_axis_tlast   // last_pixel
);

	localparam int CB    = COORD_BITS;
	localparam int CW    = lr_pkg::COLOR_BITS;
	localparam int FL_W  = $bits(lr_pkg::cmd_flags_t);
	localparam int Q_W   = FL_W + 5 * CB + (CB + 3) + CW;

	lr_pkg::cmd_flags_t f_flags, b_flags;
	logic [CB-1:0]      f_sx, f_sy, f_stop, f_dmaj, f_dmin;
	logic [CB-1:0]      b_sx, b_sy, b_stop, b_dmaj, b_dmin;
	logic [CB+2:0]      f_err, b_err;
	logic [CW-1:0]      b_color;
	logic               q_full, q_push, q_pop, q_head_valid;
	logic [Q_W-1:0]     q_push_data, q_head_data;
	logic [CB-1:0]      px, py;
	logic [CW-1:0]      pc;

	lr_front #(.COORD_BITS(CB)) u_front (
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.req_type    (s_axis_tuser),
		.x_start     (s_axis_tdata[CB-1:0]),
		.y_start     (s_axis_tdata[2*CB-1:CB]),
		.x_end       (s_axis_tdata[3*CB-1:2*CB]),
		.y_end       (s_axis_tdata[4*CB-1:3*CB]),
		.q_full      (q_full),
		.q_push      (q_push),
		.flags       (f_flags),
		.start_x     (f_sx),
		.start_y     (f_sy),
		.major_stop  (f_stop),
		.delta_major (f_dmaj),
		.delta_minor (f_dmin),
		.error_init  (f_err)
	);

	assign q_push_data = {s_axis_tdata[4*CB+CW-1:4*CB], f_err, f_dmin, f_dmaj,
		f_stop, f_sy, f_sx, f_flags};

	lr_queue #(.WIDTH(Q_W)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_push_data),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_data  (q_head_data)
	);

	assign {b_color, b_err, b_dmin, b_dmaj, b_stop, b_sy, b_sx, b_flags} = q_head_data;

	lr_back #(.COORD_BITS(CB)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (q_head_valid),
		.flags       (b_flags),
		.start_x     (b_sx),
		.start_y     (b_sy),
		.major_stop  (b_stop),
		.delta_major (b_dmaj),
		.delta_minor (b_dmin),
		.error_init  (b_err),
		.color       (b_color),
		.pop         (q_pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.pixel_x     (px),
		.pixel_y     (py),
		.pixel_color (pc),
		.last_pixel  (m_axis_tlast)
	);

	assign m_axis_tdata = OUT_W'({pc, py, px});

endmodule

`default_nettype wire

// ----- hw/rtl/lr_front.sv -----
// ---------------------------------------------------------------------------
// lr_front
// Accepts input words, tells loads from steps and works out the line setup.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lr_front #(
	parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic                    req_type,
	input  wire logic [COORD_BITS-1:0]   x_start,
	input  wire logic [COORD_BITS-1:0]   y_start,
	input  wire logic [COORD_BITS-1:0]   x_end,
	input  wire logic [COORD_BITS-1:0]   y_end,
	input  wire logic                    q_full,
	output logic                         q_push,
	output lr_pkg::cmd_flags_t           flags,
	output logic [COORD_BITS-1:0]        start_x,
	output logic [COORD_BITS-1:0]        start_y,
	output logic [COORD_BITS-1:0]        major_stop,
	output logic [COORD_BITS-1:0]        delta_major,
	output logic [COORD_BITS-1:0]        delta_minor,
	output logic [COORD_BITS+2:0]        error_init
);

	logic [COORD_BITS-1:0] dx, dy, sx, sy, ex, ey;
	logic                  steep, swap;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		dx    = (x_start > x_end) ? x_start - x_end : x_end - x_start;
		dy    = (y_start > y_end) ? y_start - y_end : y_end - y_start;
		steep = !(dy < dx);
		swap  = steep ? (y_start > y_end) : (x_start > x_end);
		if (swap) begin
			sx = x_end;
			sy = y_end;
			ex = x_start;
			ey = y_start;
		end else begin
			sx = x_start;
			sy = y_start;
			ex = x_end;
			ey = y_end;
		end
		start_x           = sx;
		start_y           = sy;
		major_stop        = steep ? ey : ex;
		delta_major       = steep ? dy : dx;
		delta_minor       = steep ? dx : dy;
		flags.is_load     = (req_type == lr_pkg::REQ_LOAD);
		flags.steep       = steep;
		flags.minor_dec   = steep ? (ex < sx) : (ey < sy);
		error_init        = {2'b00, delta_minor, 1'b0} - {3'b000, delta_major};
	end

endmodule

`default_nettype wire

// ----- hw/rtl/lr_queue.sv -----
// ---------------------------------------------------------------------------
// lr_queue
// Short first-in first-out queue between the front and the back part.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lr_queue #(
	parameter int WIDTH = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [WIDTH-1:0]  push_data,
	output logic                   full,
	input  wire logic              pop,
	output logic                   head_valid,
	output logic [WIDTH-1:0]       head_data
);

	localparam int DEPTH = lr_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/lr_back.sv -----
// ---------------------------------------------------------------------------
// lr_back
// Holds the line state, steps it one pixel at a time and drives the output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lr_back #(
	parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          head_valid,
	input  wire lr_pkg::cmd_flags_t            flags,
	input  wire logic [COORD_BITS-1:0]         start_x,
	input  wire logic [COORD_BITS-1:0]         start_y,
	input  wire logic [COORD_BITS-1:0]         major_stop,
	input  wire logic [COORD_BITS-1:0]         delta_major,
	input  wire logic [COORD_BITS-1:0]         delta_minor,
	input  wire logic [COORD_BITS+2:0]         error_init,
	input  wire logic [lr_pkg::COLOR_BITS-1:0] color,
	output logic                               pop,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [COORD_BITS-1:0]              pixel_x,
	output logic [COORD_BITS-1:0]              pixel_y,
	output logic [lr_pkg::COLOR_BITS-1:0]      pixel_color,
	output logic                               last_pixel
);

	localparam int ERR_W = COORD_BITS + 3;

	logic                          busy_q, steep_q, minor_dec_q;
	logic [COORD_BITS-1:0]         cur_x_q, cur_y_q, stop_q, dmaj_q, dmin_q;
	logic signed [ERR_W-1:0]       err_q;
	logic [lr_pkg::COLOR_BITS-1:0] color_q;

	logic                          out_valid_q, last_q;
	logic [COORD_BITS-1:0]         px_q, py_q;
	logic [lr_pkg::COLOR_BITS-1:0] pc_q;

	logic                          out_free, emit, load, last, err_pos;
	logic [COORD_BITS-1:0]         major, minor, major_inc, minor_nxt;
	logic signed [ERR_W-1:0]       err_nxt, dmin2, dmaj2;

	always_comb begin
		out_free  = !out_valid_q || out_ready;
		load      = head_valid && flags.is_load;
		emit      = head_valid && !flags.is_load && busy_q && out_free;
		pop       = head_valid && (flags.is_load || !busy_q || out_free);
		major     = steep_q ? cur_y_q : cur_x_q;
		minor     = steep_q ? cur_x_q : cur_y_q;
		major_inc = major + COORD_BITS'(1);
		last      = (major_inc == stop_q);
		err_pos   = (err_q > 0);
		dmin2     = $signed({2'b00, dmin_q, 1'b0});
		dmaj2     = $signed({2'b00, dmaj_q, 1'b0});
		if (err_pos) begin
			minor_nxt = minor_dec_q ? minor - COORD_BITS'(1) : minor + COORD_BITS'(1);
			err_nxt   = err_q + dmin2 - dmaj2;
		end else begin
			minor_nxt = minor;
			err_nxt   = err_q + dmin2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= (delta_major != '0);
			end else if (emit && last) begin
				busy_q <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			steep_q     <= flags.steep;
			minor_dec_q <= flags.minor_dec;
			cur_x_q     <= start_x;
			cur_y_q     <= start_y;
			stop_q      <= major_stop;
			dmaj_q      <= delta_major;
			dmin_q      <= delta_minor;
			err_q       <= $signed(error_init);
			color_q     <= color;
		end else if (emit) begin
			cur_x_q <= steep_q ? minor_nxt : major_inc;
			cur_y_q <= steep_q ? major_inc : minor_nxt;
			err_q   <= err_nxt;
		end
		if (emit) begin
			px_q   <= cur_x_q;
			py_q   <= cur_y_q;
			pc_q   <= color_q;
			last_q <= last;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = px_q;
	assign pixel_y     = py_q;
	assign pixel_color = pc_q;
	assign last_pixel  = last_q;

endmodule

`default_nettype wire

// ----- hw/rtl/lr_checker.sv -----
// ---------------------------------------------------------------------------
// lr_checker
// Port-level checks on the line rasterizer, bound to its top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lr_checker #(
	parameter int  COORD_BITS = lr_pkg::COORD_BITS_DEF,
	localparam int IN_W  = ((4 * COORD_BITS + lr_pkg::COLOR_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((2 * COORD_BITS + lr_pkg::COLOR_BITS + 7) / 8) * 8
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_axis_tvalid,
	input wire logic             s_axis_tready,
	input wire logic [IN_W-1:0]  s_axis_tdata,
	input wire logic             s_axis_tuser,
	input wire logic             m_axis_tvalid,
	input wire logic             m_axis_tready,
	input wire logic [OUT_W-1:0] m_axis_tdata,
	input wire logic             m_axis_tlast
);

	`ASSERT_CLK(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output word dropped while stalled")
	`ASSERT_CLK(a_out_stable, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast), "output word changed while stalled")
	`ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !m_axis_tvalid, "output word shown during reset")
	`ASSERT_ALWAYS(a_ready_after_reset, clk, arst_n && $past(!arst_n) |-> s_axis_tready && !m_axis_tvalid, "block not empty after reset")

endmodule

bind line_rasterizer lr_checker #(.COORD_BITS(COORD_BITS)) u_lr_checker (.*);

`default_nettype wire

// ----- dv/line_rasterizer_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// line_rasterizer_tb
// Self-checking bench for the Bresenham line rasterizer. A short table of
// load and step words covers reset, the edges of the coordinate space, both
// octant cases, reversed endpoints, lines replaced mid-way, zero-length lines
// and steps while idle. Random lines follow. Every pixel that comes out is
// checked against the table or an in-bench stepper model. Both stream sides
// stall at random; twice the output side holds off until the input backs up.
// ---------------------------------------------------------------------------

module line_rasterizer_tb;

	localparam int CB           = lr_pkg::COORD_BITS_DEF;
	localparam int CW           = lr_pkg::COLOR_BITS;
	localparam int IN_W         = ((4 * CB + CW + 7) / 8) * 8;
	localparam int OUT_W        = ((2 * CB + CW + 7) / 8) * 8;
	localparam int ERR_W        = CB + 3;
	localparam int COORD_MAX    = (1 << CB) - 1;
	localparam int GAP_MAX      = 17;
	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 20;
	localparam int ITEM_TARGET  = 1800;

	typedef logic [CB-1:0]         coord_t;
	typedef logic [CW-1:0]         color_t;
	typedef logic [IN_W-1:0]       in_bus_t;
	typedef logic signed [ERR_W-1:0] err_t;

	typedef struct {
		lr_pkg::req_type_t req;
		coord_t    xs, ys, xe, ye;
		color_t    color;
	} line_word_t;

	typedef struct {
		coord_t x, y;
		color_t color;
		logic   last;
	} pixel_t;

	typedef enum {ROW_PREDICTED, ROW_QUIET, ROW_PIXEL} row_kind_t;

	typedef struct {
		row_kind_t  kind;
		line_word_t w;
		pixel_t     pix;
	} stim_row_t;

	logic             clk           = 1'b0;
	logic             arst_n;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata  = '0;
	logic             s_axis_tuser  = 1'b0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic             m_axis_tlast;

	logic   ln_busy      = 1'b0;
	logic   ln_steep     = 1'b0;
	logic   ln_minor_dec = 1'b0;
	coord_t ln_x         = '0;
	coord_t ln_y         = '0;
	coord_t ln_stop      = '0;
	coord_t ln_dmajor    = '0;
	coord_t ln_dminor    = '0;
	err_t   ln_err       = '0;
	color_t ln_color     = '0;

	pixel_t      pixels_due[$];
	stim_row_t   dir_rows[$];
	int unsigned items_done   = 0;
	int unsigned mismatches   = 0;
	int unsigned quiet_cycles = 0;
	bit          calm_send    = 1'b0;
	bit          calm_recv    = 1'b0;

	line_rasterizer #(
		.COORD_BITS(CB)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= STALL_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic bit rasterize_word(input line_word_t w, output pixel_t p);
		coord_t sx, sy, ex, ey, dx, dy, major, minor;
		logic   last;
		p = '{default: '0};
		if (w.req == lr_pkg::REQ_LOAD) begin
			dx = (w.xs > w.xe) ? w.xs - w.xe : w.xe - w.xs;
			dy = (w.ys > w.ye) ? w.ys - w.ye : w.ye - w.ys;
			ln_color = w.color;
			ln_steep = !(dy < dx);
			if (ln_steep ? (w.ys > w.ye) : (w.xs > w.xe)) begin
				sx = w.xe; sy = w.ye; ex = w.xs; ey = w.ys;
			end else begin
				sx = w.xs; sy = w.ys; ex = w.xe; ey = w.ye;
			end
			ln_x = sx;
			ln_y = sy;
			ln_stop      = ln_steep ? ey : ex;
			ln_dmajor    = ln_steep ? dy : dx;
			ln_dminor    = ln_steep ? dx : dy;
			ln_minor_dec = ln_steep ? (ex < sx) : (ey < sy);
			ln_err  = err_t'(2 * int'(ln_dminor) - int'(ln_dmajor));
			ln_busy = ln_dmajor != 0;
			return 1'b0;
		end
		if (!ln_busy) begin
			return 1'b0;
		end
		major = ln_steep ? ln_y : ln_x;
		minor = ln_steep ? ln_x : ln_y;
		last  = coord_t'(major + 1'b1) == ln_stop;
		p.x     = ln_x;
		p.y     = ln_y;
		p.color = ln_color;
		p.last  = last;
		if (ln_err > 0) begin
			minor  = ln_minor_dec ? minor - 1'b1 : minor + 1'b1;
			ln_err = ln_err - err_t'(2 * int'(ln_dmajor));
		end
		ln_err = ln_err + err_t'(2 * int'(ln_dminor));
		major  = major + 1'b1;
		if (ln_steep) begin
			ln_y = major;
			ln_x = minor;
		end else begin
			ln_x = major;
			ln_y = minor;
		end
		if (last) begin
			ln_busy = 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic stim_row_t stim_row(row_kind_t k, lr_pkg::req_type_t r, int xs, int ys,
			int xe, int ye, color_t c, int px, int py, color_t pc, bit pl);
		stim_row_t s;
		s.kind      = k;
		s.w.req     = r;
		s.w.xs      = coord_t'(xs);
		s.w.ys      = coord_t'(ys);
		s.w.xe      = coord_t'(xe);
		s.w.ye      = coord_t'(ye);
		s.w.color   = c;
		s.pix.x     = coord_t'(px);
		s.pix.y     = coord_t'(py);
		s.pix.color = pc;
		s.pix.last  = pl;
		return s;
	endfunction

	function automatic coord_t nudge(coord_t base, int d);
		int t;
		t = ($urandom_range(0, 1) != 0) ? int'(base) + d : int'(base) - d;
		if (t > COORD_MAX) t = COORD_MAX;
		if (t < 0) t = 0;
		return coord_t'(t);
	endfunction

	function automatic line_word_t step_word();
		line_word_t w;
		w.req   = lr_pkg::REQ_STEP;
		w.xs    = coord_t'($urandom);
		w.ys    = coord_t'($urandom);
		w.xe    = coord_t'($urandom);
		w.ye    = coord_t'($urandom);
		w.color = $urandom;
		return w;
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	task automatic send_word(input line_word_t w, output bit made_pixel, output pixel_t p);
		int gap;
		if ($urandom_range(0, 63) == 0) calm_send = !calm_send;
		gap = calm_send ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= w.req;
		s_axis_tdata  <= in_bus_t'({w.color, w.ye, w.xe, w.ys, w.xs});
		do @(posedge clk); while (!s_axis_tready);
		made_pixel = rasterize_word(w, p);
	endtask

	task automatic issue_word(input line_word_t w);
		bit     got;
		pixel_t p;
		send_word(w, got, p);
		if (got) pixels_due.push_back(p);
		items_done++;
	endtask

	task automatic random_line();
		line_word_t w;
		int mode, span, dmaj, dmin, steps;
		mode = $urandom_range(0, 99);
		span = (mode < 2) ? $urandom_range(100, COORD_MAX) : $urandom_range(0, 24);
		dmaj = span;
		dmin = (mode >= 10 && mode < 15) ? span : $urandom_range(0, span);
		w.req   = lr_pkg::REQ_LOAD;
		w.color = $urandom;
		w.xs    = coord_t'($urandom);
		w.ys    = coord_t'($urandom);
		if (mode >= 2 && mode < 10) begin
			w.xe = coord_t'($urandom);
			w.ye = coord_t'($urandom);
		end else if ($urandom_range(0, 1) != 0) begin
			w.xe = nudge(w.xs, dmaj);
			w.ye = nudge(w.ys, dmin);
		end else begin
			w.xe = nudge(w.xs, dmin);
			w.ye = nudge(w.ys, dmaj);
		end
		issue_word(w);
		steps = int'(ln_dmajor);
		if (mode >= 2 && mode < 10) begin
			steps = $urandom_range(0, 40);
		end else if (mode >= 85) begin
			steps = $urandom_range(0, steps);
		end else begin
			steps += $urandom_range(0, 2);
		end
		repeat (steps) issue_word(step_word());
	endtask

	task automatic check_pixel();
		pixel_t got, want;
		got.x     = m_axis_tdata[CB-1:0];
		got.y     = m_axis_tdata[2*CB-1:CB];
		got.color = m_axis_tdata[2*CB +: CW];
		got.last  = m_axis_tlast;
		if (pixels_due.size() == 0) begin
			report_mismatch($sformatf("pixel (%0d,%0d) color %h last %b with none pending",
				got.x, got.y, got.color, got.last));
			return;
		end
		want = pixels_due.pop_front();
		if (got.x !== want.x)
			report_mismatch($sformatf("pixel_x %0d, want %0d", got.x, want.x));
		if (got.y !== want.y)
			report_mismatch($sformatf("pixel_y %0d, want %0d", got.y, want.y));
		if (got.color !== want.color)
			report_mismatch($sformatf("pixel_color %h, want %h", got.color, want.color));
		if (got.last !== want.last)
			report_mismatch($sformatf("last_pixel %b, want %b", got.last, want.last));
	endtask

	initial begin : pixel_sink
		int          stall;
		int unsigned seen;
		seen = 0;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 63) == 0) calm_recv = !calm_recv;
			stall = calm_recv ? 0 : $urandom_range(0, GAP_MAX);
			if (seen == 150 || seen == 900) stall = HOLD_CYCLES;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			seen++;
			check_pixel();
		end
	end

	initial begin
		bit     got;
		pixel_t p;

		arst_n <= 1'b0;

		dir_rows.push_back(stim_row(ROW_QUIET,     lr_pkg::REQ_STEP, 0, 0, 0, 0, 32'h0,
			0, 0, 32'h0, 0));
		dir_rows.push_back(stim_row(ROW_QUIET,     lr_pkg::REQ_LOAD, 0, 0, 0, 0, 32'h0,
			0, 0, 32'h0, 0));
		dir_rows.push_back(stim_row(ROW_QUIET,     lr_pkg::REQ_STEP, 0, 0, 0, 0, 32'h0,
			0, 0, 32'h0, 0));
		dir_rows.push_back(stim_row(ROW_QUIET,     lr_pkg::REQ_LOAD, 0, 0, 1, 0, 32'hFFFFFFFF,
			0, 0, 32'h0, 0));
		dir_rows.push_back(stim_row(ROW_PIXEL,     lr_pkg::REQ_STEP, 0, 0, 0, 0, 32'h0,
			0, 0, 32'hFFFFFFFF, 1));
		dir_rows.push_back(stim_row(ROW_QUIET,     lr_pkg::REQ_STEP, 0, 0, 0, 0, 32'h0,
			0, 0, 32'h0, 0));
		dir_rows.push_back(stim_row(ROW_QUIET,     lr_pkg::REQ_LOAD, 1023, 1023, 0, 0,
			32'hA5A5A5A5, 0, 0, 32'h0, 0));
		dir_rows.push_back(stim_row(ROW_PIXEL,     lr_pkg::REQ_STEP, 0, 0, 0, 0, 32'h0,
			0, 0, 32'hA5A5A5A5, 0));
		dir_rows.push_back(stim_row(ROW_PREDICTED, lr_pkg::REQ_STEP, 0, 0, 0, 0, 32'h0,
			0, 0, 32'h0, 0));
		dir_rows.push_back(stim_row(ROW_PREDICTED, lr_pkg::REQ_STEP, 0, 0, 0, 0, 32'h0,
			0, 0, 32'h0, 0));
		dir_rows.push_back(stim_row(ROW_QUIET,     lr_pkg::REQ_LOAD, 1023, 0, 0, 1023,
			32'h5A5A5A5A, 0, 0, 32'h0, 0));
		dir_rows.push_back(stim_row(ROW_PIXEL,     lr_pkg::REQ_STEP, 0, 0, 0, 0, 32'h0,
			1023, 0, 32'h5A5A5A5A, 0));
		dir_rows.push_back(stim_row(ROW_PREDICTED, lr_pkg::REQ_STEP, 0, 0, 0, 0, 32'h0,
			0, 0, 32'h0, 0));
		dir_rows.push_back(stim_row(ROW_QUIET,     lr_pkg::REQ_LOAD, 0, 1023, 1023, 1000,
			32'h0000FFFF, 0, 0, 32'h0, 0));
		dir_rows.push_back(stim_row(ROW_PIXEL,     lr_pkg::REQ_STEP, 0, 0, 0, 0, 32'h0,
			0, 1023, 32'h0000FFFF, 0));
		dir_rows.push_back(stim_row(ROW_PREDICTED, lr_pkg::REQ_STEP, 0, 0, 0, 0, 32'h0,
			0, 0, 32'h0, 0));
		dir_rows.push_back(stim_row(ROW_PREDICTED, lr_pkg::REQ_STEP, 0, 0, 0, 0, 32'h0,
			0, 0, 32'h0, 0));
		dir_rows.push_back(stim_row(ROW_QUIET,     lr_pkg::REQ_LOAD, 1000, 5, 3, 7,
			32'h12345678, 0, 0, 32'h0, 0));
		dir_rows.push_back(stim_row(ROW_PIXEL,     lr_pkg::REQ_STEP, 0, 0, 0, 0, 32'h0,
			3, 7, 32'h12345678, 0));
		dir_rows.push_back(stim_row(ROW_QUIET,     lr_pkg::REQ_LOAD, 5, 10, 5, 12,
			32'hFFFF0000, 0, 0, 32'h0, 0));
		dir_rows.push_back(stim_row(ROW_PIXEL,     lr_pkg::REQ_STEP, 0, 0, 0, 0, 32'h0,
			5, 10, 32'hFFFF0000, 0));
		dir_rows.push_back(stim_row(ROW_PIXEL,     lr_pkg::REQ_STEP, 0, 0, 0, 0, 32'h0,
			5, 11, 32'hFFFF0000, 1));
		dir_rows.push_back(stim_row(ROW_QUIET,     lr_pkg::REQ_STEP, 0, 0, 0, 0, 32'h0,
			0, 0, 32'h0, 0));
		dir_rows.push_back(stim_row(ROW_QUIET,     lr_pkg::REQ_LOAD, 512, 512, 511, 512,
			32'h80000001, 0, 0, 32'h0, 0));
		dir_rows.push_back(stim_row(ROW_PIXEL,     lr_pkg::REQ_STEP, 0, 0, 0, 0, 32'h0,
			511, 512, 32'h80000001, 1));
		dir_rows.push_back(stim_row(ROW_QUIET,     lr_pkg::REQ_STEP, 0, 0, 0, 0, 32'h0,
			0, 0, 32'h0, 0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			send_word(dir_rows[i].w, got, p);
			case (dir_rows[i].kind)
				ROW_PREDICTED: begin
					if (got) pixels_due.push_back(p);
				end
				ROW_PIXEL: begin
					pixels_due.push_back(dir_rows[i].pix);
				end
				default: begin
				end
			endcase
		end

		while (items_done < ITEM_TARGET) random_line();
		s_axis_tvalid <= 1'b0;

		while (pixels_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/lr_pkg.sv
hw/rtl/lr_front.sv
hw/rtl/lr_queue.sv
hw/rtl/lr_back.sv
hw/rtl/line_rasterizer.sv
hw/rtl/lr_checker.sv
dv/line_rasterizer_tb.sv
